@@ rtl/core/rdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg: shared definitions of the radix digit converter
// Widths, register reset value, back-end state type and the digit encoder.
// ----------------------------------------------------------------------------
package rdc_pkg;

  // default sizing handed to the top level parameters
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_DIGITS_DEF  = 32;

  // fixed field widths
  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 7;

  // radix register reset and legal range
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  // ascii anchors
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd55;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_EMIT
  } bk_state_t;

  // back end control strobes
  typedef struct packed {
    logic q_pop;
    logic div_step;
    logic div_last;
    logic rd_issue;
  } bk_ctl_t;

  // digit value to ascii character, '0'-'9' then 'A'-'F'
  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + ext;
    end else begin
      return CHAR_LETTER + ext;
    end
  endfunction

endpackage

@@ rtl/core/radix_digit_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter: unsigned integer to ascii digits in a set base
// Front end queues requests, back end divides and emits digits.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_data write the radix register (reset 10); values below 2 act
//   as 2 and above 16 act as 16. Write it only while the block is idle.
//   in_valid/in_stall/in_value carry one request: an unsigned value.
//   out_valid/out_stall carry one character per digit, most significant
//   digit first, '0'-'9' then 'A'-'F'; out_last_digit marks the final one.
//   Zero gives the single character '0'; at most MAX_DIGITS low digits.
// Timing:
//   each digit takes a full pass of the bit-serial divider over the value,
//   and all digits of a request are divided out before its first
//   character appears.
//   A two-entry request queue takes new requests while the back end is
//   busy; in_stall rises only when it is full.
//   A stall on the result side holds the output register and the pop of the
//   digit stack; once the last digit is read, the divider of the next
//   request runs while that digit waits.
// Reset:
//   synchronous rst_n clears the queue, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module radix_digit_converter #(
  parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = rdc_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rdc_pkg::RADIX_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [VALUE_WIDTH-1:0]      in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rdc_pkg::CHAR_W-1:0]  out_digit_char,
  output logic                        out_last_digit
);

  logic                        q_valid;
  logic                        q_pop;
  logic [VALUE_WIDTH-1:0]      q_value;
  logic [rdc_pkg::RADIX_W-1:0] q_base;

  // request intake and queue
  rdc_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_value  (q_value),
    .q_base   (q_base)
  );

  // digit generation and emission
  rdc_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_value        (q_value),
    .q_base         (q_base),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule

@@ rtl/core/rdc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_ram: generic single write, single read memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rdc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/rdc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_front: request intake of the radix digit converter
// Holds the radix register, clamps the base and queues requests for the back.
// ----------------------------------------------------------------------------
module rdc_front #(
  parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic [rdc_pkg::RADIX_W-1:0] cfg_data,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [VALUE_WIDTH-1:0]      in_value,
  // queue head toward the back end
  output logic                        q_valid,
  input  logic                        q_pop,
  output logic [VALUE_WIDTH-1:0]      q_value,
  output logic [rdc_pkg::RADIX_W-1:0] q_base
);

  localparam int QDEPTH = 2;
  localparam int PW     = $clog2(QDEPTH);
  localparam int CW     = $clog2(QDEPTH + 1);

  logic [rdc_pkg::RADIX_W-1:0] radix_r;
  logic [rdc_pkg::RADIX_W-1:0] base_clamp;
  logic [VALUE_WIDTH-1:0]      val_q_r  [QDEPTH];
  logic [rdc_pkg::RADIX_W-1:0] base_q_r [QDEPTH];
  logic [PW-1:0]               wr_ptr_r;
  logic [PW-1:0]               rd_ptr_r;
  logic [CW-1:0]               count_r;
  logic [CW-1:0]               count_nxt;
  logic                        push;

  // radix register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= rdc_pkg::RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_data;
    end
  end

  // base clamped into the supported range
  always_comb begin
    if (radix_r < rdc_pkg::RADIX_MIN) begin
      base_clamp = rdc_pkg::RADIX_MIN;
    end else if (radix_r > rdc_pkg::RADIX_MAX) begin
      base_clamp = rdc_pkg::RADIX_MAX;
    end else begin
      base_clamp = radix_r;
    end
  end

  // queue handshake
  assign in_stall = (count_r == CW'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_value  = val_q_r[rd_ptr_r];
  assign q_base   = base_q_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!push && q_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // queue pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      val_q_r[wr_ptr_r]  <= in_value;
      base_q_r[wr_ptr_r] <= base_clamp;
    end
  end

endmodule

@@ rtl/core/rdc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_back: digit generation and emission of the radix digit converter
// Bit-serial division by the base fills a digit stack, which is then popped.
// ----------------------------------------------------------------------------
module rdc_back #(
  parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = rdc_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // queue head from the front end
  input  logic                        q_valid,
  output logic                        q_pop,
  input  logic [VALUE_WIDTH-1:0]      q_value,
  input  logic [rdc_pkg::RADIX_W-1:0] q_base,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rdc_pkg::CHAR_W-1:0]  out_digit_char,
  output logic                        out_last_digit
);

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int BW = $clog2(VALUE_WIDTH);

  rdc_pkg::bk_state_t state_r;
  rdc_pkg::bk_state_t state_nxt;
  rdc_pkg::bk_ctl_t   ctl;

  logic [VALUE_WIDTH-1:0]      d_r;
  logic [rdc_pkg::RADIX_W-1:0] base_r;
  logic [rdc_pkg::DIGIT_W-1:0] rem_r;
  logic [BW-1:0]               bit_r;
  logic [CW-1:0]               cnt_r;
  logic [CW-1:0]               cnt_inc;
  logic                        rd_pend_r;
  logic                        last_pend_r;
  logic                        out_valid_r;
  logic [rdc_pkg::CHAR_W-1:0]  out_char_r;
  logic                        out_last_r;
  logic                        out_fire;
  logic                        more_digits;

  logic [rdc_pkg::RADIX_W-1:0] trial;
  logic                        ge;
  logic [rdc_pkg::RADIX_W-1:0] diff;
  logic [rdc_pkg::DIGIT_W-1:0] rem_new;
  logic [VALUE_WIDTH-1:0]      d_shift;
  logic [rdc_pkg::DIGIT_W-1:0] ram_rdata;

  // one restoring division step
  assign trial   = {rem_r, d_r[VALUE_WIDTH-1]};
  assign ge      = (trial >= base_r);
  assign diff    = trial - base_r;
  assign rem_new = ge ? diff[rdc_pkg::DIGIT_W-1:0] : trial[rdc_pkg::DIGIT_W-1:0];
  assign d_shift = {d_r[VALUE_WIDTH-2:0], ge};

  assign cnt_inc     = cnt_r + CW'(1);
  assign more_digits = (d_shift != '0) && (cnt_inc < CW'(MAX_DIGITS));
  assign out_fire    = out_valid_r && !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rdc_pkg::BK_IDLE: begin
        if (q_valid) begin
          state_nxt = rdc_pkg::BK_DIV;
        end
      end
      rdc_pkg::BK_DIV: begin
        if (bit_r == BW'(VALUE_WIDTH - 1) && !more_digits) begin
          state_nxt = rdc_pkg::BK_EMIT;
        end
      end
      rdc_pkg::BK_EMIT: begin
        if (cnt_r == '0 && !rd_pend_r) begin
          state_nxt = rdc_pkg::BK_IDLE;
        end
      end
      default: state_nxt = rdc_pkg::BK_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    ctl = '0;
    case (state_r)
      rdc_pkg::BK_IDLE: begin
        ctl.q_pop = q_valid;
      end
      rdc_pkg::BK_DIV: begin
        ctl.div_step = 1'b1;
        ctl.div_last = (bit_r == BW'(VALUE_WIDTH - 1));
      end
      rdc_pkg::BK_EMIT: begin
        ctl.rd_issue = (cnt_r != '0) && !rd_pend_r && (!out_valid_r || out_fire);
      end
      default: ctl = '0;
    endcase
  end

  assign q_pop = ctl.q_pop;

  // state and control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rdc_pkg::BK_IDLE;
      cnt_r     <= '0;
      bit_r     <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= ctl.rd_issue;
      if (ctl.q_pop) begin
        cnt_r <= '0;
        bit_r <= '0;
      end else if (ctl.div_step) begin
        bit_r <= ctl.div_last ? '0 : bit_r + BW'(1);
        if (ctl.div_last) begin
          cnt_r <= cnt_inc;
        end
      end else if (ctl.rd_issue) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // division datapath
  always_ff @(posedge clk) begin
    if (ctl.q_pop) begin
      d_r    <= q_value;
      base_r <= q_base;
      rem_r  <= '0;
    end else if (ctl.div_step) begin
      d_r   <= d_shift;
      rem_r <= ctl.div_last ? '0 : rem_new;
    end
    if (ctl.rd_issue) begin
      last_pend_r <= (cnt_r == CW'(1));
    end
  end

  // digit stack
  rdc_ram #(
    .WIDTH (rdc_pkg::DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_stack (
    .clk   (clk),
    .we    (ctl.div_last),
    .waddr (cnt_r[AW-1:0]),
    .wdata (rem_new),
    .raddr (AW'(cnt_r - CW'(1))),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rd_pend_r) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      out_char_r <= rdc_pkg::ascii_of(ram_rdata);
      out_last_r <= last_pend_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

endmodule
